// File: hw/rtl/bsw_pkg.sv
// Package for the BMP stream writer: byte positions in the file layout,
// fixed header byte values and the header byte lookup function.
// No dependencies.
`default_nettype none

package bsw_pkg;

    localparam int DIM_W  = 13;          // width of the dimension registers
    localparam int ROWB_W = DIM_W + 2;   // width of the padded row byte count
    localparam int DATA_W = DIM_W + ROWB_W;
    localparam int SIZE_W = 32;          // header size fields
    localparam int POS_W  = 6;           // byte position within one transfer group

    // Byte positions of the header fields and the pixel bytes.
    localparam logic [POS_W-1:0] POS_SIG_B   = 6'd0;
    localparam logic [POS_W-1:0] POS_SIG_M   = 6'd1;
    localparam logic [POS_W-1:0] POS_FSIZE   = 6'd2;
    localparam logic [POS_W-1:0] POS_OFFSET  = 6'd10;
    localparam logic [POS_W-1:0] POS_INFO    = 6'd14;
    localparam logic [POS_W-1:0] POS_WIDTH   = 6'd18;
    localparam logic [POS_W-1:0] POS_HEIGHT  = 6'd22;
    localparam logic [POS_W-1:0] POS_PLANES  = 6'd26;
    localparam logic [POS_W-1:0] POS_BPP     = 6'd28;
    localparam logic [POS_W-1:0] POS_DSIZE   = 6'd34;
    localparam logic [POS_W-1:0] POS_BLUE    = 6'd54;
    localparam logic [POS_W-1:0] POS_GREEN   = 6'd55;
    localparam logic [POS_W-1:0] POS_RED     = 6'd56;

    localparam logic [SIZE_W-1:0] HEADER_BYTES = 32'd54;

    localparam logic [7:0] SIG_B_BYTE  = 8'h42;
    localparam logic [7:0] SIG_M_BYTE  = 8'h4D;
    localparam logic [7:0] OFFSET_BYTE = 8'h36;
    localparam logic [7:0] INFO_BYTE   = 8'h28;
    localparam logic [7:0] PLANES_BYTE = 8'h01;
    localparam logic [7:0] BPP_BYTE    = 8'h18;
    localparam logic [7:0] WHITE_BYTE  = 8'hFF;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    // One byte of the 54-byte header; multi-byte fields are little endian.
    function automatic logic [7:0] header_byte(
        input logic [POS_W-1:0]  pos,
        input logic [SIZE_W-1:0] fsize,
        input logic [SIZE_W-1:0] width,
        input logic [SIZE_W-1:0] height,
        input logic [SIZE_W-1:0] dsize
    );
        logic [7:0] b;
        b = ZERO_BYTE;
        case (pos)
            POS_SIG_B:         b = SIG_B_BYTE;
            POS_SIG_M:         b = SIG_M_BYTE;
            POS_FSIZE:         b = fsize[7:0];
            POS_FSIZE + 6'd1:  b = fsize[15:8];
            POS_FSIZE + 6'd2:  b = fsize[23:16];
            POS_FSIZE + 6'd3:  b = fsize[31:24];
            POS_OFFSET:        b = OFFSET_BYTE;
            POS_INFO:          b = INFO_BYTE;
            POS_WIDTH:         b = width[7:0];
            POS_WIDTH + 6'd1:  b = width[15:8];
            POS_WIDTH + 6'd2:  b = width[23:16];
            POS_WIDTH + 6'd3:  b = width[31:24];
            POS_HEIGHT:        b = height[7:0];
            POS_HEIGHT + 6'd1: b = height[15:8];
            POS_HEIGHT + 6'd2: b = height[23:16];
            POS_HEIGHT + 6'd3: b = height[31:24];
            POS_PLANES:        b = PLANES_BYTE;
            POS_BPP:           b = BPP_BYTE;
            POS_DSIZE:         b = dsize[7:0];
            POS_DSIZE + 6'd1:  b = dsize[15:8];
            POS_DSIZE + 6'd2:  b = dsize[23:16];
            POS_DSIZE + 6'd3:  b = dsize[31:24];
            default:           b = ZERO_BYTE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bmp_stream_writer.sv
// BMP stream writer top level: turns a pixel stream into a 24-bit BMP byte stream.
// Depends on bsw_pkg for byte positions, header constants and the header lookup.
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  pixels   | s_valid s_ready s_red s_green s_blue           | in
//           | s_pixel_present                                |
//  bytes    | m_valid m_ready m_out_byte m_run_last          | out
//           | m_frame_last                                   |
//  config   | cfg_wr_en cfg_index cfg_wdata                  | in
//
// Each pixel transfer yields 3 to 6 bytes, plus 54 header bytes for the first pixel
// of a frame, one byte per cycle unless m_ready stalls the output. The byte sequencer
// feeds its one-byte output register; the next pixel is taken in the cycle the last
// byte of the current one moves to that register. Reset (aresetn low, synchronous)
// clears the counters, sets the header pending and sets both dimensions to 1.
// A stall on m_ready holds the output register and the sequencer in place.
`default_nettype none

module bmp_stream_writer #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_index,
    input  wire logic [bsw_pkg::DIM_W-1:0] cfg_wdata,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [7:0]               s_red,
    input  wire logic [7:0]               s_green,
    input  wire logic [7:0]               s_blue,
    input  wire logic                     s_pixel_present,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_run_last,
    output logic                          m_frame_last
);

    localparam int DIM_W    = bsw_pkg::DIM_W;
    localparam int POS_W    = bsw_pkg::POS_W;
    localparam int SIZE_W   = bsw_pkg::SIZE_W;
    localparam int CNT_W    = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int CMP_W    = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;
    localparam int DIM_TOP  = (1 << DIM_W) - 1;
    localparam int MAX_CLIP = (MAX_DIMENSION > DIM_TOP) ? DIM_TOP : MAX_DIMENSION;
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_CLIP);

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Configuration registers.
    logic [DIM_W-1:0] width_cfg_reg, height_cfg_reg;

    // Frame position.
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             hdr_pend_reg, hdr_pend_next;

    // Byte sequencer holding the pixel currently being written out.
    logic                     seq_vld_reg, seq_vld_next;
    logic [POS_W-1:0]         seq_pos_reg, seq_pos_next;
    logic [POS_W-1:0]         seq_last_reg;
    logic                     seq_fend_reg;
    logic [7:0]               seq_b_reg, seq_g_reg, seq_r_reg;
    logic [DIM_W-1:0]         seq_w_reg, seq_h_reg;
    logic [bsw_pkg::DATA_W-1:0] seq_dsize_reg;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_run_last_reg, m_frame_last_reg;

    logic [DIM_W-1:0]           w_eff, h_eff;
    logic [1:0]                 pad;
    logic [bsw_pkg::ROWB_W-1:0] row_bytes;
    logic [bsw_pkg::DATA_W-1:0] dsize;
    logic                       row_end, frame_end;
    logic                       accept, advance, seq_done, at_last;
    logic [SIZE_W-1:0]          fsize;

    always_comb begin
        w_eff = width_cfg_reg;
        if (width_cfg_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (width_cfg_reg > MAX_DIM_V) begin
            w_eff = MAX_DIM_V;
        end
        h_eff = height_cfg_reg;
        if (height_cfg_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (height_cfg_reg > MAX_DIM_V) begin
            h_eff = MAX_DIM_V;
        end
    end

    // Row padding to a multiple of four bytes equals width mod 4.
    assign pad       = w_eff[1:0];
    assign row_bytes = bsw_pkg::ROWB_W'(w_eff) * bsw_pkg::ROWB_W'(3)
                     + bsw_pkg::ROWB_W'(pad);
    assign dsize     = bsw_pkg::DATA_W'(h_eff) * bsw_pkg::DATA_W'(row_bytes);

    assign row_end   = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(w_eff);
    assign frame_end = row_end && ((CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(h_eff));

    assign at_last  = (seq_pos_reg == seq_last_reg);
    assign advance  = seq_vld_reg && (!m_valid_reg || m_ready);
    assign seq_done = advance && at_last;
    assign s_ready  = !seq_vld_reg || seq_done;
    assign accept   = s_valid && s_ready;

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        hdr_pend_next = hdr_pend_reg;
        if (accept) begin
            hdr_pend_next = frame_end;
            if (row_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + CNT_W'(1);
            end else begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        seq_vld_next = seq_vld_reg;
        seq_pos_next = seq_pos_reg;
        if (accept) begin
            seq_vld_next = 1'b1;
            seq_pos_next = hdr_pend_reg ? bsw_pkg::POS_SIG_B : bsw_pkg::POS_BLUE;
        end else if (seq_done) begin
            seq_vld_next = 1'b0;
        end else if (advance) begin
            seq_pos_next = seq_pos_reg + POS_W'(1);
        end
    end

    assign fsize = SIZE_W'(seq_dsize_reg) + bsw_pkg::HEADER_BYTES;

    always_comb begin
        if (seq_pos_reg == bsw_pkg::POS_BLUE) begin
            m_byte_next = seq_b_reg;
        end else if (seq_pos_reg == bsw_pkg::POS_GREEN) begin
            m_byte_next = seq_g_reg;
        end else if (seq_pos_reg == bsw_pkg::POS_RED) begin
            m_byte_next = seq_r_reg;
        end else if (seq_pos_reg > bsw_pkg::POS_RED) begin
            m_byte_next = bsw_pkg::ZERO_BYTE;
        end else begin
            m_byte_next = bsw_pkg::header_byte(seq_pos_reg, fsize, SIZE_W'(seq_w_reg),
                                               SIZE_W'(seq_h_reg), SIZE_W'(seq_dsize_reg));
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= DIM_W'(1);
            height_cfg_reg <= DIM_W'(1);
            col_reg        <= '0;
            row_reg        <= '0;
            hdr_pend_reg   <= 1'b1;
            seq_vld_reg    <= 1'b0;
            seq_pos_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WIDTH:  width_cfg_reg  <= cfg_wdata;
                    CFG_HEIGHT: height_cfg_reg <= cfg_wdata;
                    default:    width_cfg_reg  <= width_cfg_reg;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            hdr_pend_reg <= hdr_pend_next;
            seq_vld_reg  <= seq_vld_next;
            seq_pos_reg  <= seq_pos_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seq_last_reg  <= bsw_pkg::POS_RED + POS_W'(row_end ? pad : 2'd0);
            seq_fend_reg  <= frame_end;
            seq_b_reg     <= s_pixel_present ? s_blue  : bsw_pkg::WHITE_BYTE;
            seq_g_reg     <= s_pixel_present ? s_green : bsw_pkg::WHITE_BYTE;
            seq_r_reg     <= s_pixel_present ? s_red   : bsw_pkg::WHITE_BYTE;
            seq_w_reg     <= w_eff;
            seq_h_reg     <= h_eff;
            seq_dsize_reg <= dsize;
        end
        if (advance) begin
            m_byte_reg       <= m_byte_next;
            m_run_last_reg   <= at_last;
            m_frame_last_reg <= at_last && seq_fend_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_frame_last = m_frame_last_reg;

`ifndef SYNTHESIS
    // The end of the file is always the end of a pixel's byte group.
    a_frame_last_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_run_last)
        else $error("frame_last without run_last");

    // The sequencer never walks past the last byte of its pixel.
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_vld_reg |-> seq_pos_reg <= seq_last_reg)
        else $error("byte position past end of pixel group");

    // An accepted pixel is in the sequencer on the next cycle.
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> seq_vld_reg)
        else $error("accepted pixel not loaded");

    // A byte leaves the sequencer only when the output register can take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_byte) && m_valid)
        else $error("output byte overwritten while stalled");

    // A pixel that ends a frame re-arms the header for the next one.
    a_header_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && frame_end |=> hdr_pend_reg)
        else $error("header not re-armed after frame end");
`endif

endmodule

`default_nettype wire

// File: tb/sv/bmp_stream_writer_test.sv
// Self-checking testbench for bmp_stream_writer: drives pixel transfers, predicts
// the 24-bit BMP byte stream and compares every output transfer against it.
// Depends on bsw_pkg and the bmp_stream_writer RTL.
module bmp_stream_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_DIM        = 4096;
    localparam logic        REG_WIDTH      = 1'b0;
    localparam logic        REG_HEIGHT     = 1'b1;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned RANDOM_PIXELS  = 80;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       frame_last;
    } file_byte_t;

    // Holds the bytes the file stream must contain, in order, and the writer's
    // own view of the frame position.
    class bmp_byte_scoreboard;
        file_byte_t  expected_bytes[$];
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        int unsigned col_pos;
        int unsigned row_pos;
        bit          header_due;
        int unsigned failures;
        int unsigned bytes_seen;

        function new();
            width_reg  = 13'd1;
            height_reg = 13'd1;
            col_pos    = 0;
            row_pos    = 0;
            header_due = 1'b1;
            failures   = 0;
            bytes_seen = 0;
        endfunction

        function void write_reg(logic idx, logic [12:0] value);
            if (idx == REG_WIDTH)
                width_reg = value;
            else
                height_reg = value;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // Out-of-range dimensions are used as the nearest legal value.
        function logic [31:0] used_dim(logic [12:0] value);
            if (value == 13'd0)
                return 32'd1;
            if (value > MAX_DIM)
                return MAX_DIM;
            return {19'd0, value};
        endfunction

        function void add_byte(logic [7:0] value);
            file_byte_t entry;
            entry.data       = value;
            entry.run_last   = 1'b0;
            entry.frame_last = 1'b0;
            expected_bytes.insert(expected_bytes.size(), entry);
        endfunction

        function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                 logic present);
            logic [31:0] w;
            logic [31:0] h;
            logic [31:0] pad;
            logic [31:0] data_size;
            logic [31:0] file_size;
            logic [7:0]  hdr [54];
            bit          frame_done;
            int          k;
            w = used_dim(width_reg);
            h = used_dim(height_reg);
            pad = (32'd4 - ((w * 32'd3) % 32'd4)) % 32'd4;
            frame_done = 1'b0;
            if (header_due) begin
                data_size = h * (w * 32'd3 + pad);
                file_size = bsw_pkg::HEADER_BYTES + data_size;
                for (k = 0; k < 54; k++)
                    hdr[k] = bsw_pkg::ZERO_BYTE;
                hdr[bsw_pkg::POS_SIG_B]  = bsw_pkg::SIG_B_BYTE;
                hdr[bsw_pkg::POS_SIG_M]  = bsw_pkg::SIG_M_BYTE;
                hdr[bsw_pkg::POS_OFFSET] = bsw_pkg::OFFSET_BYTE;
                hdr[bsw_pkg::POS_INFO]   = bsw_pkg::INFO_BYTE;
                hdr[bsw_pkg::POS_PLANES] = bsw_pkg::PLANES_BYTE;
                hdr[bsw_pkg::POS_BPP]    = bsw_pkg::BPP_BYTE;
                // Multi-byte header fields go out least significant byte first.
                for (k = 0; k < 4; k++) begin
                    hdr[bsw_pkg::POS_FSIZE + k]  = file_size[8*k +: 8];
                    hdr[bsw_pkg::POS_WIDTH + k]  = w[8*k +: 8];
                    hdr[bsw_pkg::POS_HEIGHT + k] = h[8*k +: 8];
                    hdr[bsw_pkg::POS_DSIZE + k]  = data_size[8*k +: 8];
                end
                for (k = 0; k < 54; k++)
                    add_byte(hdr[k]);
                header_due = 1'b0;
            end
            if (!present) begin
                red   = bsw_pkg::WHITE_BYTE;
                green = bsw_pkg::WHITE_BYTE;
                blue  = bsw_pkg::WHITE_BYTE;
            end
            add_byte(blue);
            add_byte(green);
            add_byte(red);
            if (col_pos + 1 >= w) begin
                for (k = 0; k < pad; k++)
                    add_byte(bsw_pkg::ZERO_BYTE);
                col_pos = 0;
                frame_done = (row_pos + 1 >= h);
                if (frame_done) begin
                    row_pos = 0;
                    header_due = 1'b1;
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos++;
            end
            expected_bytes[expected_bytes.size()-1].run_last   = 1'b1;
            expected_bytes[expected_bytes.size()-1].frame_last = frame_done;
        endfunction

        function void check_byte(logic [7:0] data, logic run_last, logic frame_last);
            file_byte_t want;
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("byte %0d: none expected, got %02h run_last %0b frame_last %0b",
                             bytes_seen, data, run_last, frame_last);
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data || run_last !== want.run_last ||
                frame_last !== want.frame_last) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             bytes_seen, want.data, want.run_last, want.frame_last,
                             data, run_last, frame_last);
            end
        endfunction
    endclass

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic        cfg_index       = REG_WIDTH;
    logic [12:0] cfg_wdata       = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_red           = '0;
    logic [7:0]  s_green         = '0;
    logic [7:0]  s_blue          = '0;
    logic        s_pixel_present = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_frame_last;

    bmp_byte_scoreboard sb = new();

    int unsigned burst_left    = 0;
    bit          steady_sender = 1'b0;
    bit          hold_request  = 1'b0;
    int unsigned random_pixels = 0;

    bmp_stream_writer #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_pixel_present(s_pixel_present),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_run_last     (m_run_last),
        .m_frame_last   (m_frame_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_byte(m_out_byte, m_run_last, m_frame_last);
    end

    // The receiver switches between stall patterns; on request it holds off
    // for a long stretch so the writer backs up into its input.
    initial begin : byte_receiver
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        logic [7:0]  mask;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            mask = 8'($urandom);
            for (k = 0; k < span; k++) begin
                @(posedge aclk);
                if (hold_request) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_request = 1'b0;
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= mask[k % 8];
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // The sender works in bursts unless set steady; between bursts valid drops for a random gap.
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic present);
        int unsigned gap;
        if (!steady_sender && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                              : $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left != 0)
            burst_left--;
        s_valid         <= 1'b1;
        s_red           <= red;
        s_green         <= green;
        s_blue          <= blue;
        s_pixel_present <= present;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(red, green, blue, present);
    endtask

    task automatic send_random_pixel();
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Dimensions are only changed once the writer has gone idle.
    task automatic configure(input logic [12:0] w, input logic [12:0] h);
        wait_for_drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        sb.write_reg(REG_WIDTH, w);
        cfg_index <= REG_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        sb.write_reg(REG_HEIGHT, h);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned count;
        int          k;
        logic [12:0] w;
        logic [12:0] h;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One-pixel frames at the reset size: black, white and an absent pixel.
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h12, 8'h34, 8'h56, 1'b0);

        // Zero dimensions are used as one.
        configure(13'd0, 13'd0);
        send_pixel(8'h01, 8'h80, 8'h7F, 1'b1);

        // Oversized dimensions clamp to the maximum; the frame is then cut short
        // by shrinking the dimensions below the current position.
        configure(13'h1FFF, 13'h1FFF);
        send_random_pixel();
        send_random_pixel();
        configure(13'(MAX_DIM), 13'(MAX_DIM));
        send_random_pixel();
        configure(13'd2, 13'd1);
        send_random_pixel();

        // Three padding bytes per row, then rows that need no padding.
        configure(13'd3, 13'd2);
        for (k = 0; k < 6; k++)
            send_pixel(k[0] ? 8'hAA : 8'h55, k[0] ? 8'h55 : 8'hAA, k[0] ? 8'hAA : 8'h55,
                       k[0]);
        configure(13'd4, 13'd1);
        for (k = 0; k < 4; k++)
            send_random_pixel();

        // The loop always reaches the phase with the long receiver hold.
        phase = 0;
        while (random_pixels < RANDOM_PIXELS || phase <= 3) begin
            if (phase == 3) begin
                w = 13'd4;
                h = 13'd3;
                count = 12;
            end else if ($urandom_range(0, 9) == 0) begin
                // Any register value, with a few pixels of the frame only.
                w = 13'($urandom_range(0, 8191));
                h = 13'($urandom_range(0, 8191));
                count = $urandom_range(1, 4);
            end else begin
                w = 13'($urandom_range(1, 6));
                h = 13'($urandom_range(1, 4));
                count = w * h * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0)
                    count = count + $urandom_range(1, 3);
            end
            configure(w, h);
            steady_sender = (phase == 3) || ($urandom_range(0, 3) == 0);
            burst_left = 0;
            if (phase == 3)
                hold_request = 1'b1;
            repeat (count) begin
                send_random_pixel();
                random_pixels++;
            end
            phase++;
        end

        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
